// ----- src/wlcl_pkg.sv -----
package wlcl_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgBlackLevel = 3'd0,
    CfgWhiteLevel = 3'd1,
    CfgRampSize   = 3'd2,
    CfgReverseMap = 3'd3,
    CfgFalseColor = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0] RstBlackLevel = 8'd0;
  localparam logic [7:0] RstWhiteLevel = 8'd255;
  localparam logic [8:0] RstRampSize   = 9'd256;

  // Divider layout: eight quotient bits, two per pipeline stage
  localparam int QuoW      = 8;
  localparam int DivSteps  = 2;
  localparam int DivStages = QuoW / DivSteps;

  // Values derived from the configuration, shared by all stages
  typedef struct packed {
    logic [8:0] lo;
    logic [8:0] hi;
    logic [8:0] span;
    logic       rev;
    logic [8:0] size;
    logic       false_color;
  } setup_t;

  // Flags carried through the first divider
  typedef struct packed {
    logic in_range;
    logic below;
    logic above;
    logic dsat;
    logic is_first;
    logic is_last;
  } front_side_t;

  // Flags and grey value carried through the second divider
  typedef struct packed {
    logic       in_range;
    logic       gsat;
    logic [7:0] grey;
  } grey_side_t;

  // floor(x / 255), exact for any x up to 255 * 256
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[16:8];
  endfunction

  // One restoring step: remainder stays below the divisor (at most 256)
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic bit_in,
                                          input logic [8:0] divisor);
    logic [8:0] t;
    logic [8:0] res;
    t = {rem, bit_in};
    if (t >= divisor) begin
      res = {1'b1, 8'(t - divisor)};
    end else begin
      res = {1'b0, t[7:0]};
    end
    return res;
  endfunction

endpackage

// ----- src/wlcl_setup.sv -----
module wlcl_setup #(
  parameter int LUT_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  output wlcl_pkg::setup_t    setup
);

  localparam logic [8:0] LutSize = 9'(LUT_ENTRIES);

  logic [7:0]  black_level;
  logic [7:0]  white_level;
  logic [8:0]  ramp_size;
  logic        reverse_map;
  logic        false_color;

  logic [8:0]  size;
  logic [7:0]  diff;
  logic [16:0] pb_full;
  logic [16:0] pw_full;
  logic [16:0] pd_full;

  logic [15:0] prod_blk;
  logic [15:0] prod_wht;
  logic [15:0] prod_diff;
  logic        wht_gt_blk;
  logic        rev_cfg;

  logic [8:0]  lo_raw;
  logic [8:0]  hi_raw;
  logic [8:0]  sp_raw;
  logic        swap;
  logic        span_used;

  logic [8:0]  lo;
  logic [8:0]  hi;
  logic [8:0]  span;
  logic        rev;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      black_level <= wlcl_pkg::RstBlackLevel;
      white_level <= wlcl_pkg::RstWhiteLevel;
      ramp_size   <= wlcl_pkg::RstRampSize;
      reverse_map <= 1'b0;
      false_color <= 1'b0;
    end else if (cfg_valid) begin
      case (wlcl_pkg::cfg_reg_t'(cfg_index))
        wlcl_pkg::CfgBlackLevel: black_level <= cfg_data[7:0];
        wlcl_pkg::CfgWhiteLevel: white_level <= cfg_data[7:0];
        wlcl_pkg::CfgRampSize:   ramp_size   <= cfg_data;
        wlcl_pkg::CfgReverseMap: reverse_map <= cfg_data[0];
        wlcl_pkg::CfgFalseColor: false_color <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp ramp size to the table length; zero selects the full table
  assign size = (ramp_size == 9'd0 || ramp_size > LutSize) ? LutSize : ramp_size;

  // Scale levels by the ramp size
  assign diff    = (white_level > black_level) ? (white_level - black_level)
                                               : (black_level - white_level);
  assign pb_full = {9'd0, black_level} * {8'd0, size};
  assign pw_full = {9'd0, white_level} * {8'd0, size};
  assign pd_full = {9'd0, diff} * {8'd0, size};

  always_ff @(posedge clk) begin
    prod_blk   <= pb_full[15:0];
    prod_wht   <= pw_full[15:0];
    prod_diff  <= pd_full[15:0];
    wht_gt_blk <= white_level > black_level;
    rev_cfg    <= reverse_map;
  end

  // Divide by 255, order the bounds, clamp the span
  assign lo_raw    = wlcl_pkg::div255(prod_blk);
  assign hi_raw    = wlcl_pkg::div255(prod_wht);
  assign sp_raw    = wlcl_pkg::div255(prod_diff);
  assign swap      = lo_raw > hi_raw;
  assign span_used = (swap || wht_gt_blk) && (sp_raw != 9'd0);

  always_ff @(posedge clk) begin
    lo   <= swap ? hi_raw : lo_raw;
    hi   <= swap ? lo_raw : hi_raw;
    span <= span_used ? sp_raw : 9'd1;
    rev  <= rev_cfg ^ swap;
  end

  assign setup.lo          = lo;
  assign setup.hi          = hi;
  assign setup.span        = span;
  assign setup.rev         = rev;
  assign setup.size        = size;
  assign setup.false_color = false_color;

endmodule

// ----- src/wlcl_front.sv -----
module wlcl_front #(
  parameter int LUT_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_index,
  input  wlcl_pkg::setup_t        setup,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_rem,
  output wlcl_pkg::front_side_t   out_side
);

  localparam logic [7:0] LastIdx = 8'(LUT_ENTRIES - 1);

  logic       vld0;
  logic [7:0] idx0;
  logic       vld1;
  logic [7:0] idx1;
  logic       inr1;
  logic       first1;
  logic       last1;

  logic       rdy0;
  logic       rdy1;
  logic       rdy2;

  logic       below;
  logic       above;
  logic [7:0] d;

  // Ready chain: a stage takes an item when empty or draining
  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !vld1 || rdy2;
  assign rdy0     = !vld0 || rdy1;
  assign in_ready = rdy0 && !rst;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld0      <= 1'b0;
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) vld0 <= in_valid;
      if (rdy1) vld1 <= vld0;
      if (rdy2) out_valid <= vld1;
    end
  end

  // Classify the index against the ramp bounds
  assign below = {1'b0, idx1} < setup.lo;
  assign above = {1'b0, idx1} >= setup.hi;
  assign d     = idx1 - setup.lo[7:0];

  // Hold payload per stage
  always_ff @(posedge clk) begin
    if (rdy0) idx0 <= in_index;
    if (rdy1) begin
      idx1   <= idx0;
      inr1   <= {1'b0, idx0} < setup.size;
      first1 <= idx0 == 8'd0;
      last1  <= idx0 == LastIdx;
    end
    if (rdy2) begin
      out_rem           <= d;
      out_side.in_range <= inr1;
      out_side.below    <= below;
      out_side.above    <= above;
      out_side.dsat     <= {1'b0, d} >= setup.span;
      out_side.is_first <= first1;
      out_side.is_last  <= last1;
    end
  end

endmodule

// ----- src/wlcl_div.sv -----
module wlcl_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rem,
  input  logic [7:0]        in_low,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [8:0]        divisor,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int Stages = wlcl_pkg::DivStages;
  localparam int Steps  = wlcl_pkg::DivSteps;
  localparam int QuoW   = wlcl_pkg::QuoW;

  logic              vld      [Stages];
  logic              rdy      [Stages];
  logic [7:0]        rem      [Stages];
  logic [7:0]        low      [Stages];
  logic [QuoW-1:0]   quo      [Stages];
  logic [SIDE_W-1:0] side     [Stages];

  logic              src_vld  [Stages];
  logic [7:0]        src_rem  [Stages];
  logic [7:0]        src_low  [Stages];
  logic [QuoW-1:0]   src_quo  [Stages];
  logic [SIDE_W-1:0] src_side [Stages];

  logic [7:0]        rem_nx   [Stages];
  logic [7:0]        low_nx   [Stages];
  logic [QuoW-1:0]   quo_nx   [Stages];

  // Ready chain from the output back
  always_comb begin
    rdy[Stages-1] = !vld[Stages-1] || out_ready;
    for (int s = Stages - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  // Feed each stage from the one before it
  always_comb begin
    src_vld[0]  = in_valid;
    src_rem[0]  = in_rem;
    src_low[0]  = in_low;
    src_quo[0]  = '0;
    src_side[0] = in_side;
    for (int s = 1; s < Stages; s++) begin
      src_vld[s]  = vld[s-1];
      src_rem[s]  = rem[s-1];
      src_low[s]  = low[s-1];
      src_quo[s]  = quo[s-1];
      src_side[s] = side[s-1];
    end
  end

  // Two restoring steps per stage
  always_comb begin
    logic [8:0]      st;
    logic [7:0]      r;
    logic [7:0]      l;
    logic [QuoW-1:0] q;
    for (int s = 0; s < Stages; s++) begin
      r = src_rem[s];
      l = src_low[s];
      q = src_quo[s];
      for (int k = 0; k < Steps; k++) begin
        st = wlcl_pkg::div_step(r, l[7], divisor);
        r  = st[7:0];
        q  = {q[QuoW-2:0], st[8]};
        l  = {l[6:0], 1'b0};
      end
      rem_nx[s] = r;
      low_nx[s] = l;
      quo_nx[s] = q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    for (int s = 0; s < Stages; s++) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= src_vld[s];
      end
    end
  end

  // Hold payload per stage
  always_ff @(posedge clk) begin
    for (int s = 0; s < Stages; s++) begin
      if (rdy[s]) begin
        rem[s]  <= rem_nx[s];
        low[s]  <= low_nx[s];
        quo[s]  <= quo_nx[s];
        side[s] <= src_side[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[Stages-1];
  assign out_quo   = quo[Stages-1];
  assign out_side  = side[Stages-1];

endmodule

// ----- src/wlcl_mid.sv -----
module wlcl_mid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_quo,
  input  wlcl_pkg::front_side_t  in_side,
  input  logic                   rev,
  input  logic [8:0]             size,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_rem,
  output logic [7:0]             out_low,
  output wlcl_pkg::grey_side_t   out_side
);

  logic        vld_a;
  logic [7:0]  grey_a;
  logic        inr_a;

  logic        rdy_a;
  logic        rdy_b;

  logic [7:0]  v_ramp;
  logic [7:0]  v_end;
  logic [7:0]  v_out;
  logic [15:0] n;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !vld_a || rdy_b;
  assign in_ready = rdy_a;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) vld_a <= in_valid;
      if (rdy_b) out_valid <= vld_a;
    end
  end

  // Pick the grey level, force the ends, apply reversal
  always_comb begin
    if (in_side.below) begin
      v_ramp = 8'd0;
    end else if (in_side.above || in_side.dsat) begin
      v_ramp = 8'd255;
    end else begin
      v_ramp = in_quo;
    end
    if (in_side.is_first) begin
      v_end = 8'd0;
    end else if (in_side.is_last) begin
      v_end = 8'd255;
    end else begin
      v_end = v_ramp;
    end
    if (!rev) begin
      v_out = v_end;
    end else if (v_end == 8'd0) begin
      v_out = 8'd255;
    end else begin
      v_out = 8'(9'd256 - {1'b0, v_end});
    end
  end

  // Scale grey by 255 and split for the second divider
  assign n = {grey_a, 8'd0} - {8'd0, grey_a};

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      grey_a <= v_out;
      inr_a  <= in_side.in_range;
    end
    if (rdy_b) begin
      out_rem           <= n[15:8];
      out_low           <= n[7:0];
      out_side.in_range <= inr_a;
      out_side.gsat     <= {1'b0, n[15:8]} >= size;
      out_side.grey     <= grey_a;
    end
  end

endmodule

// ----- src/wlcl_back.sv -----
module wlcl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_quo,
  input  wlcl_pkg::grey_side_t  in_side,
  input  logic                  false_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  in_range
);

  logic [7:0] red_nx;
  logic [7:0] green_nx;
  logic [7:0] blue_nx;
  logic [7:0] up;
  logic [7:0] down;

  assign in_ready = !out_valid || out_ready;

  // Rising and falling slopes of the color ramp within one quarter
  assign up   = {in_quo[5:0], 2'b00};
  assign down = {~in_quo[5:0], 2'b00};

  // Map grey to output color
  always_comb begin
    red_nx   = 8'd0;
    green_nx = 8'd0;
    blue_nx  = 8'd0;
    if (!in_side.in_range) begin
      red_nx   = 8'd0;
    end else if (!false_color) begin
      red_nx   = in_side.grey;
      green_nx = in_side.grey;
      blue_nx  = in_side.grey;
    end else if (in_side.gsat) begin
      red_nx   = 8'd255;
    end else begin
      case (in_quo[7:6])
        2'd0: begin
          green_nx = up;
          blue_nx  = 8'd255;
        end
        2'd1: begin
          green_nx = 8'd255;
          blue_nx  = down;
        end
        2'd2: begin
          red_nx   = up;
          green_nx = 8'd255;
        end
        default: begin
          red_nx   = 8'd255;
          green_nx = down;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      red      <= red_nx;
      green    <= green_nx;
      blue     <= blue_nx;
      in_range <= in_side.in_range;
    end
  end

endmodule

// ----- src/window_level_color_lut_unit.sv -----
// Channel   Dir  Handshake                     Payload
// cfg       in   cfg_valid / cfg_ready         cfg_index (register), cfg_data
// s_axis    in   s_axis_tvalid / s_axis_tready s_axis_tdata: entry_index
// m_axis    out  m_axis_tvalid / m_axis_tready m_axis_tdata: red, green, blue
//                                              m_axis_tuser: in_range
//
// One item per cycle unless m_axis stalls; stages: front 3, two 4-stage
// dividers each retiring two quotient bits per stage, mid 2, output 1.
// rst is synchronous; s_axis_tready is low while it is high.
// Every stage holds its item while the next is full, so a stalled m_axis
// backs up stage by stage and empty stages keep filling meanwhile.
// cfg_ready is always high; bounds settle via product, then bound registers.
module window_level_color_lut_unit #(
  parameter int LUT_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] entry_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tuser    // [0] in_range
);

  localparam int FrontSideW = $bits(wlcl_pkg::front_side_t);
  localparam int GreySideW  = $bits(wlcl_pkg::grey_side_t);

  wlcl_pkg::setup_t       setup;

  logic                   f_valid;
  logic                   f_ready;
  logic [7:0]             f_rem;
  wlcl_pkg::front_side_t  f_side;

  logic                   d1_valid;
  logic                   d1_ready;
  logic [7:0]             d1_quo;
  logic [FrontSideW-1:0]  d1_side;

  logic                   m_valid;
  logic                   m_ready;
  logic [7:0]             m_rem;
  logic [7:0]             m_low;
  wlcl_pkg::grey_side_t   m_side;

  logic                   d2_valid;
  logic                   d2_ready;
  logic [7:0]             d2_quo;
  logic [GreySideW-1:0]   d2_side;

  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   in_range;

  assign cfg_ready = 1'b1;

  wlcl_setup #(
    .LUT_ENTRIES (LUT_ENTRIES)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .setup     (setup)
  );

  wlcl_front #(
    .LUT_ENTRIES (LUT_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_index  (s_axis_tdata),
    .setup     (setup),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_rem   (f_rem),
    .out_side  (f_side)
  );

  // Ramp position: (index - lo) * 256 / span
  wlcl_div #(
    .SIDE_W (FrontSideW)
  ) u_div_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rem    (f_rem),
    .in_low    (8'd0),
    .in_side   (f_side),
    .divisor   (setup.span),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  wlcl_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_ready  (d1_ready),
    .in_quo    (d1_quo),
    .in_side   (d1_side),
    .rev       (setup.rev),
    .size      (setup.size),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_rem   (m_rem),
    .out_low   (m_low),
    .out_side  (m_side)
  );

  // False color position: grey * 255 / ramp size
  wlcl_div #(
    .SIDE_W (GreySideW)
  ) u_div_color (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_rem    (m_rem),
    .in_low    (m_low),
    .in_side   (m_side),
    .divisor   (setup.size),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  wlcl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d2_valid),
    .in_ready    (d2_ready),
    .in_quo      (d2_quo),
    .in_side     (d2_side),
    .false_color (setup.false_color),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .in_range    (in_range)
  );

  assign m_axis_tdata = {blue, green, red};
  assign m_axis_tuser = in_range;

endmodule

// ----- verif/tb_window_level_color_lut_unit.sv -----
module tb_window_level_color_lut_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LutEntries  = 256;
  localparam int PipeLatency = 14;
  localparam int RandPhases  = 20;
  localparam int PhaseItems  = 100;

  // Colormap predictor and the queue of colors the DUT still owes it
  class colormap_scoreboard;
    typedef struct {
      logic [7:0] entry;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_range;
    } color_t;

    logic [7:0] black_level = wlcl_pkg::RstBlackLevel;
    logic [7:0] white_level = wlcl_pkg::RstWhiteLevel;
    logic [8:0] ramp_size   = wlcl_pkg::RstRampSize;
    logic       reverse_map = 1'b0;
    logic       false_color = 1'b0;
    color_t     expected_colors[$];
    int         mismatches;

    function void write_reg(logic [2:0] idx, logic [8:0] data);
      case (wlcl_pkg::cfg_reg_t'(idx))
        wlcl_pkg::CfgBlackLevel: black_level = data[7:0];
        wlcl_pkg::CfgWhiteLevel: white_level = data[7:0];
        wlcl_pkg::CfgRampSize:   ramp_size   = data;
        wlcl_pkg::CfgReverseMap: reverse_map = data[0];
        wlcl_pkg::CfgFalseColor: false_color = data[0];
        default: ;
      endcase
    endfunction

    // Zero or oversize ramp falls back to the full table
    function int unsigned active_size();
      if (ramp_size == 9'd0 || 32'(ramp_size) > LutEntries) return LutEntries;
      return 32'(ramp_size);
    endfunction

    // Windowed grey level of one entry, reversal applied
    function int unsigned grey_level(int unsigned idx, int unsigned r);
      int unsigned blk, wht, lo, hi, tmp, span, v;
      bit rev;
      blk = 32'(black_level);
      wht = 32'(white_level);
      lo  = blk * r / 255;
      hi  = wht * r / 255;
      rev = reverse_map;
      if (lo > hi) begin
        tmp = lo;  lo  = hi;  hi  = tmp;
        tmp = blk; blk = wht; wht = tmp;
        rev = !rev;
      end
      span = 1;
      if (wht > blk) begin
        span = (wht - blk) * r / 255;
        if (span < 1) span = 1;
      end
      if (idx < lo) v = 0;
      else if (idx >= hi) v = 255;
      else begin
        v = (idx - lo) * 256 / span;
        if (v > 255) v = 255;
      end
      // Table ends are pinned to black and white
      if (idx == 0) v = 0;
      if (idx == LutEntries - 1) v = 255;
      if (rev) v = (v == 0) ? 255 : 256 - v;
      return v;
    endfunction

    function void note_entry(logic [7:0] entry);
      color_t c;
      int unsigned r, v, g;
      r = active_size();
      c.entry = entry;
      c.red = 8'd0; c.green = 8'd0; c.blue = 8'd0; c.in_range = 1'b0;
      if (32'(entry) < r) begin
        v = grey_level(32'(entry), r);
        c.in_range = 1'b1;
        if (!false_color) begin
          c.red = 8'(v); c.green = 8'(v); c.blue = 8'(v);
        end else begin
          // Blue-green-red ramp in four segments
          g = v * 255 / r;
          if (g < 64) begin
            c.green = 8'(g * 4); c.blue = 8'd255;
          end else if (g < 128) begin
            c.green = 8'd255; c.blue = 8'((127 - g) * 4);
          end else if (g < 192) begin
            c.red = 8'((g - 128) * 4); c.green = 8'd255;
          end else begin
            c.red = 8'd255;
            c.green = (g <= 255) ? 8'((255 - g) * 4) : 8'd0;
          end
        end
      end
      expected_colors.push_back(c);
    endfunction

    function void check_color(logic [23:0] data, logic user);
      color_t c;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: r=%0d g=%0d b=%0d in_range=%0b",
                   data[7:0], data[15:8], data[23:16], user);
        return;
      end
      c = expected_colors.pop_front();
      if (data[7:0] !== c.red || data[15:8] !== c.green ||
          data[23:16] !== c.blue || user !== c.in_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("entry %0d: exp r=%0d g=%0d b=%0d ok=%0b, got r=%0d g=%0d b=%0d ok=%0b",
                   c.entry, c.red, c.green, c.blue, c.in_range,
                   data[7:0], data[15:8], data[23:16], user);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  colormap_scoreboard sb;
  bit in_accepted;
  bit cfg_accepted;

  window_level_color_lut_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample every handshake at the rising edge
  always @(posedge clk) begin
    in_accepted  = !rst && s_axis_tvalid && s_axis_tready;
    cfg_accepted = !rst && cfg_valid && cfg_ready;
    if (cfg_accepted) sb.write_reg(cfg_index, cfg_data);
    if (in_accepted) sb.note_entry(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_color(m_axis_tdata, m_axis_tuser);
  end

  // Receiver backpressure: switch at random between stall patterns
  initial begin
    int mode, mode_left, tick;
    m_axis_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (tick % 4 != 0);
      endcase
    end
  end

  // Present one entry and hold it until taken
  task automatic send_entry(logic [7:0] entry);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= entry;
    do @(negedge clk); while (!in_accepted);
  endtask

  // Hold one register write until taken; the caller lowers cfg_valid
  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_accepted);
  endtask

  // Stop sending, wait for every owed color, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_colors.size() != 0) @(negedge clk);
    repeat (PipeLatency + 2) @(negedge clk);
  endtask

  task automatic apply_config(logic [8:0] blk, logic [8:0] wht, logic [8:0] ramp,
                              logic [8:0] rev, logic [8:0] fc);
    drain();
    // Occasionally poke an unused register index first
    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(5, 7)), 9'($urandom_range(0, 511)));
    write_reg(wlcl_pkg::CfgBlackLevel, blk);
    write_reg(wlcl_pkg::CfgWhiteLevel, wht);
    write_reg(wlcl_pkg::CfgRampSize,   ramp);
    write_reg(wlcl_pkg::CfgReverseMap, rev);
    write_reg(wlcl_pkg::CfgFalseColor, fc);
    cfg_valid <= 1'b0;
    // Give the derived bounds time to settle
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] pick_ramp();
    case ($urandom_range(0, 7))
      0:       return 9'd1;
      1:       return 9'd2;
      2:       return 9'd255;
      3:       return 9'd256;
      4:       return 9'd0;
      5:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  // One-bit flag, sometimes with junk in the upper bits
  function automatic logic [8:0] pick_flag();
    logic [8:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 255)) : 9'd0;
    return {junk[7:0], 1'($urandom_range(0, 1))};
  endfunction

  // Random phase: fresh settings, then entries in bursts, sometimes with gaps
  task automatic random_phase();
    logic [7:0] blk, wht;
    int unsigned r, sent, burst, gap;
    bit no_gaps;
    blk = pick_level();
    wht = ($urandom_range(0, 4) == 0) ? blk : pick_level();
    apply_config({1'($urandom_range(0, 1)), blk}, {1'($urandom_range(0, 1)), wht},
                 pick_ramp(), pick_flag(), pick_flag());
    r = sb.active_size();
    no_gaps = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < PhaseItems) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < PhaseItems; k++) begin
        // Mostly entries inside the ramp, some anywhere in the table
        if ($urandom_range(0, 4) == 0) send_entry(8'($urandom_range(0, 255)));
        else send_entry(8'($urandom_range(0, r - 1)));
        sent++;
      end
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = wlcl_pkg::CfgBlackLevel;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: pinned ends and the middle of the table
    send_entry(8'd0);
    send_entry(8'd1);
    send_entry(8'd127);
    send_entry(8'd128);
    send_entry(8'd254);
    send_entry(8'd255);

    // Black above white: bounds swap and the ramp inverts
    apply_config(9'd200, 9'd50, 9'd256, 9'd0, 9'd0);
    send_entry(8'd0);
    send_entry(8'd100);
    send_entry(8'd200);
    send_entry(8'd255);

    // Equal levels give a unit span; reversal on; entry past the ramp
    apply_config(9'd100, 9'd100, 9'd100, 9'd1, 9'd0);
    send_entry(8'd0);
    send_entry(8'd39);
    send_entry(8'd40);
    send_entry(8'd99);
    send_entry(8'd100);

    // Short ramp in false color: scaled grey overshoots 255
    apply_config(9'd0, 9'd255, 9'd10, 9'd0, 9'd1);
    send_entry(8'd0);
    send_entry(8'd5);
    send_entry(8'd9);
    send_entry(8'd10);

    // Zero ramp size acts as the full table; all four color segments
    apply_config(9'd0, 9'd255, 9'd0, 9'd1, 9'd1);
    send_entry(8'd0);
    send_entry(8'd64);
    send_entry(8'd128);
    send_entry(8'd192);
    send_entry(8'd255);

    repeat (RandPhases) random_phase();

    drain();
    if (sb.mismatches == 0 && sb.expected_colors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
src/wlcl_pkg.sv
src/wlcl_setup.sv
src/wlcl_front.sv
src/wlcl_div.sv
src/wlcl_mid.sv
src/wlcl_back.sv
src/window_level_color_lut_unit.sv
verif/tb_window_level_color_lut_unit.sv
